### rtl/core/lkv_pkg.sv
// Shared constants and types for the LRU key-value cache.
// No dependencies; imported by lkv_cell, lru_key_value_cache_top and its testbench.
package lkv_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned OCC_W     = $clog2(ENTRIES + 1);
  localparam int unsigned EC_W      = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             look;
    logic             hit;
    logic             full;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

### rtl/core/lkv_cell.sv
// One slot of the recency-ordered entry chain.
// Depends on lkv_pkg for entry_t and cell_ctrl_t.
module lkv_cell import lkv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     prev_i,
  input  logic       next_valid_i,
  input  logic       shift_i,
  output logic       shift_o,
  output entry_t     entry_o,
  output logic       match_o
);

  logic             valid_q;
  logic             match_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic             stop;

  // Stop the shift wave at the hit slot, or for an insert at the first free
  // slot, or at the last used slot when the cache is full.
  assign stop    = ctrl_i.hit ? match_q : (!valid_q || (ctrl_i.full && !next_valid_i));
  assign shift_o = shift_i && !stop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.look) begin
        match_q <= valid_q && (key_q == ctrl_i.key);
      end
      if (shift_i) begin
        valid_q <= prev_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= prev_i.key;
      value_q <= prev_i.value;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.key   = key_q;
  assign entry_o.value = value_q;
  assign match_o       = match_q;

endmodule

### rtl/core/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: request sequencer and cell chain.
// Depends on lkv_pkg and lkv_cell.
//
// Fully associative key-value cache with least-recently-used replacement.
// Entries sit in a chain of cells ordered by recency, most recent first. A
// transaction passes through acceptance, a compare cycle in which every
// cell matches the key at once, and an update cycle in which, on a hit or
// a set, the chain shifts by one up to the hit slot, the first free slot
// or, when full, the least recent slot, which drops out. The shift wave
// through the chain sets the update cycle. A get holds in its update cycle
// while the previous result has not been taken. A get returns hit and the
// stored value, or hit clear and all ones; a set returns nothing. Capacity
// writes are taken only between transactions and win over a request
// offered in the same cycle. Capacity zero acts as one and values above the
// slot count saturate. The chain is empty after reset.
module lru_key_value_cache_top import lkv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_capacity_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    operation_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic signed [VAL_W-1:0] read_value_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_e;

  state_e           state_q;
  op_e              op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [OCC_W-1:0] occ_q;
  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  logic             hit_q;
  logic [VAL_W-1:0] read_value_q;

  entry_t           ent [ENTRIES];
  logic [ENTRIES:0] shift;
  logic [ENTRIES-1:0] match;
  entry_t           head;
  cell_ctrl_t       ctrl;
  logic             hit_any;
  logic [VAL_W-1:0] hit_val;
  logic [EC_W-1:0]  eff_cap;
  logic             full;
  logic             can_emit;
  logic             upd;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val = hit_val | (ent[i].value & {VAL_W{match[i]}});
    end
  end

  always_comb begin
    priority if (cap_q == '0) begin
      eff_cap = EC_W'(1);
    end else if (EC_W'(cap_q) > EC_W'(ENTRIES)) begin
      eff_cap = EC_W'(ENTRIES);
    end else begin
      eff_cap = EC_W'(cap_q);
    end
  end

  assign hit_any  = |match;
  assign full     = EC_W'(occ_q) >= eff_cap;
  assign can_emit = !out_valid_q || out_ready_i;
  assign upd      = (state_q == ST_UPD) && ((op_q == OP_SET) || can_emit);
  assign shift[0] = upd && (hit_any || (op_q == OP_SET));

  assign head.valid = 1'b1;
  assign head.key   = key_q;
  assign head.value = (op_q == OP_SET) ? value_q : hit_val;

  assign ctrl.look = (state_q == ST_LOOK);
  assign ctrl.hit  = hit_any;
  assign ctrl.full = full;
  assign ctrl.key  = key_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t prev;
    logic   next_valid;
    if (g == 0) begin : g_first
      assign prev = head;
    end else begin : g_mid
      assign prev = ent[g-1];
    end
    if (g == ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_valid = ent[g+1].valid;
    end
    lkv_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_i       (prev),
      .next_valid_i (next_valid),
      .shift_i      (shift[g]),
      .shift_o      (shift[g+1]),
      .entry_o      (ent[g]),
      .match_o      (match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_GET;
      key_q        <= '0;
      value_q      <= '0;
      occ_q        <= '0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      read_value_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !(upd && (op_q == OP_GET))) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q    <= op_e'(operation_i);
            key_q   <= key_i;
            value_q <= value_i;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (upd) begin
            state_q <= ST_IDLE;
            if (op_q == OP_GET) begin
              out_valid_q  <= 1'b1;
              hit_q        <= hit_any;
              read_value_q <= hit_any ? hit_val : READ_MISS;
            end else if (!hit_any && !full) begin
              occ_q <= occ_q + OCC_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o  = (state_q == ST_IDLE);
  assign in_ready_o   = (state_q == ST_IDLE) && !cfg_valid_i;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = read_value_q;

endmodule

### verif/tb_lru_key_value_cache_top.sv
// Testbench for lru_key_value_cache_top: directed and random get/set traffic against
// an in-bench LRU cache predictor, with random stalls on both channels.
// Depends on lkv_pkg and the RTL of lru_key_value_cache_top.
`timescale 1ns / 100ps

module tb_lru_key_value_cache_top;
  import lkv_pkg::*;

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] data;
  } lookup_t;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned REPORT_MAX   = 10;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CAP_W-1:0]        cfg_capacity_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    operation_i;
  logic signed [KEY_W-1:0] key_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    hit_o;
  logic signed [VAL_W-1:0] read_value_o;

  lru_key_value_cache_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .read_value_o   (read_value_o)
  );

  logic [KEY_W-1:0] cache_keys [ENTRIES];
  logic [VAL_W-1:0] cache_vals [ENTRIES];
  bit               cache_used [ENTRIES];
  int unsigned      cache_age  [ENTRIES];
  int unsigned      cache_count;
  logic [CAP_W-1:0] cache_cap;

  lookup_t          lookups_due [$];
  logic [KEY_W-1:0] key_pool [$];

  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned hold_left;
  int unsigned fault_count;
  int unsigned cycle_count;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** lru_key_value_cache_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_used[i] && cache_keys[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void make_recent(int s);
    int unsigned r;
    r = cache_age[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_used[i] && i != s && cache_age[i] < r) begin
        cache_age[i]++;
      end
    end
    cache_age[s] = 0;
  endfunction

  function automatic void insert_key(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int unsigned limit;
    int          victim;
    int          slot;
    limit  = (cache_cap == 0) ? 1 : (cache_cap > ENTRIES) ? ENTRIES : cache_cap;
    victim = -1;
    slot   = -1;
    if (cache_count >= limit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_used[i] && (victim < 0 || cache_age[i] > cache_age[victim])) begin
          victim = i;
        end
      end
      if (victim >= 0) begin
        cache_used[victim] = 1'b0;
        cache_age[victim]  = 0;
        if (cache_count > 0) cache_count--;
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!cache_used[i] && slot < 0) slot = i;
    end
    if (slot < 0) return;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_used[i]) cache_age[i]++;
    end
    cache_keys[slot] = k;
    cache_vals[slot] = v;
    cache_used[slot] = 1'b1;
    cache_age[slot]  = 0;
    cache_count++;
  endfunction

  function automatic void cache_apply(op_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int      s;
    lookup_t due;
    s = find_slot(k);
    if (op == OP_GET) begin
      if (s >= 0) begin
        make_recent(s);
        due.hit  = 1'b1;
        due.data = cache_vals[s];
      end else begin
        due.hit  = 1'b0;
        due.data = READ_MISS;
      end
      lookups_due.push_back(due);
    end else if (s >= 0) begin
      cache_vals[s] = v;
      make_recent(s);
    end else begin
      insert_key(k, v);
    end
  endfunction

  task automatic send_request(op_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    value_i     <= v;
    do @(posedge clk_i); while (!in_ready_o);
    cache_apply(op, k, v);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_drain();
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cache_cap = cap;
  endtask

  task automatic fill_pool(int unsigned n);
    key_pool.delete();
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(7, 0))
        0:       key_pool.push_back(32'h8000_0000);
        1:       key_pool.push_back(32'h7FFF_FFFF);
        2:       key_pool.push_back(32'hFFFF_FFFF);
        3:       key_pool.push_back(32'h0000_0000);
        default: key_pool.push_back($urandom);
      endcase
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99, 0) < 85) begin
      return key_pool[$urandom_range(key_pool.size() - 1, 0)];
    end
    return $urandom;
  endfunction

  task automatic send_random(int unsigned n, int unsigned get_pct);
    op_e op;
    for (int unsigned i = 0; i < n; i++) begin
      op = ($urandom_range(99, 0) < get_pct) ? OP_GET : OP_SET;
      send_request(op, pick_key(), $urandom);
    end
  endtask

  task automatic test_empty_lookup();
    in_gap_max  = 15;
    out_gap_max = 15;
    send_request(OP_GET, 32'h0000_0000, $urandom);
    send_request(OP_GET, 32'hFFFF_FFFF, $urandom);
  endtask

  task automatic test_field_extremes();
    send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, $urandom);
    send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_GET, 32'h7FFF_FFFF, $urandom);
    send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'hFFFF_FFFF, $urandom);
    send_request(OP_SET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h7FFF_FFFF, $urandom);
  endtask

  task automatic test_lru_eviction();
    write_capacity(CAP_W'(2));
    send_request(OP_SET, 32'h0000_00A5, 32'h1111_1111);
    send_request(OP_SET, 32'h0000_005A, 32'h2222_2222);
    send_request(OP_GET, 32'h0000_00A5, $urandom);
    send_request(OP_SET, 32'h0000_0C3C, 32'h3333_3333);
    send_request(OP_GET, 32'h0000_005A, $urandom);
    send_request(OP_GET, 32'h0000_00A5, $urandom);
    send_request(OP_GET, 32'h0000_0C3C, $urandom);
  endtask

  task automatic test_capacity_zero();
    write_capacity(CAP_W'(0));
    send_request(OP_SET, 32'h1234_5678, 32'hDEAD_BEEF);
    send_request(OP_SET, 32'h8765_4321, 32'hCAFE_F00D);
    send_request(OP_GET, 32'h1234_5678, $urandom);
    send_request(OP_GET, 32'h8765_4321, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [10] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31,
                                    5'd2, 5'd16, 5'd9, 5'd3, 5'd12};
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      case (p % 3)
        0: begin in_gap_max = 15; out_gap_max = 15; end
        1: begin in_gap_max = 0;  out_gap_max = 0;  end
        default: begin in_gap_max = $urandom_range(1, 0) * 15; out_gap_max = 15 - in_gap_max; end
      endcase
      fill_pool($urandom_range(24, 2));
      send_random(190, 50);
    end
  endtask

  task automatic test_output_stall();
    write_capacity(CAP_W'(8));
    in_gap_max  = 0;
    out_gap_max = 0;
    fill_pool(10);
    send_random(8, 0);
    hold_left = 300;
    send_random(40, 90);
  endtask

  task automatic test_input_pause();
    in_gap_max  = 3;
    out_gap_max = 7;
    send_random(30, 60);
    wait_drain();
    send_random(30, 60);
  endtask

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      int unsigned gap;
      lookup_t     due;
      gap = $urandom_range(out_gap_max, 0);
      if (gap != 0 || hold_left != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_left != 0) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (lookups_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
          $display("unexpected result: hit %0b value %h", hit_o, read_value_o);
        end
      end else begin
        due = lookups_due.pop_front();
        if (hit_o !== due.hit || read_value_o !== due.data) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("mismatch: expected hit %0b value %h, got hit %0b value %h",
                     due.hit, due.data, hit_o, read_value_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_capacity_i <= '0;
    in_valid_i     <= 1'b0;
    operation_i    <= OP_GET;
    key_i          <= '0;
    value_i        <= '0;
    cycle_count    = 0;
    fault_count    = 0;
    hold_left      = 0;
    in_gap_max     = 0;
    out_gap_max    = 0;
    cache_cap      = CAP_RESET;
    cache_count    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_keys[i] = '0;
      cache_vals[i] = '0;
      cache_used[i] = 1'b0;
      cache_age[i]  = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookup();
    test_field_extremes();
    test_lru_eviction();
    test_capacity_zero();
    test_random_traffic();
    test_output_stall();
    test_input_pause();

    wait_drain();
    if (lookups_due.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("** lru_key_value_cache_top: PASSED **");
    end else begin
      $display("** lru_key_value_cache_top: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/lkv_pkg.sv
rtl/core/lkv_cell.sv
rtl/core/lru_key_value_cache_top.sv
verif/tb_lru_key_value_cache_top.sv
